>>> src/stt_pkg.sv
package stt_pkg;

    localparam int ID_W     = 48;
    localparam int EMA_W    = 12;
    localparam int SEEN_W   = 32;
    localparam int CHAN_W   = 4;
    localparam int RSSI_W   = 8;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 5;
    localparam int COUNT_W  = 5;

    localparam logic [SEEN_W-1:0] DROP_AGE_RESET = 32'd25000;

    localparam logic [CMD_W-1:0] CMD_BEACON = 2'd0;
    localparam logic [CMD_W-1:0] CMD_AGE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_AGED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_LIST     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;

    typedef enum logic [1:0] {
        WD_UPD,
        WD_TGT,
        WD_RD,
        WD_HOLD
    } t_wd_sel;

    typedef enum logic [1:0] {
        REC_WD,
        REC_RD,
        REC_WEAK,
        REC_ZERO
    } t_rec_sel;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [EMA_W-1:0]  ema;
        logic [SEEN_W-1:0]        seen;
        logic [CHAN_W-1:0]        chan;
    } t_entry;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [SLOT_W-1:0]        slot;
        logic [ID_W-1:0]          id;
        logic signed [EMA_W-1:0]  ema;
        logic [CHAN_W-1:0]        chan;
    } t_rec;

    typedef struct packed {
        logic                load_in;
        logic                rd_en;
        logic                wr_en;
        t_wd_sel             wd_sel;
        logic                load_weak;
        logic                load_hold;
        logic                rec_wr;
        t_rec_sel            rec_sel;
        logic [STATUS_W-1:0] rec_status;
        logic                res_rd_en;
    } t_ctl;

    typedef struct packed {
        logic match;
        logic rd_less_weak;
        logic rd_less_hold;
        logic aged;
        logic tgt_le_weak;
    } t_sts;

endpackage

>>> src/signal_tracking_table.sv
// Radio source tracking table.
// Input channel (i_in_valid/o_in_ready) carries one command transaction:
// a beacon (lookup, update, insert, weakest replacement or rejection), an end of pass
// (remove entries older than the drop age) or an end of sweep (stable sort,
// strongest first, then list every entry).
// Output channel (o_out_valid/i_out_ready) returns zero to TABLE_DEPTH result
// transactions per command; o_final_item marks the last one and
// o_entry_count is the table occupancy after the whole command.
// Config channel (i_cfg_valid/o_cfg_ready) writes the drop age; write it
// only while no command is in flight.
// The beacon lookup walks the entry memory one read per cycle. Ageing
// visits each entry in turn and the sweep sorts by insertion before it
// lists every entry. Each result is read from the result buffer; a
// stalled result holds and the next command is taken only after the
// last result of the current one.
// Reset empties the table and loads the drop age with 25000 ms.
module signal_tracking_table #(
    parameter int TABLE_DEPTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [stt_pkg::SEEN_W-1:0]          i_cfg_drop_age_ms,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [stt_pkg::CMD_W-1:0]           i_cmd,
    input  logic [stt_pkg::ID_W-1:0]            i_source_id,
    input  logic signed [stt_pkg::RSSI_W-1:0]   i_rssi_dbm,
    input  logic [stt_pkg::CHAN_W-1:0]          i_chan,
    input  logic [stt_pkg::SEEN_W-1:0]          i_now_ms,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [stt_pkg::STATUS_W-1:0]        o_status,
    output logic [stt_pkg::SLOT_W-1:0]          o_slot,
    output logic [stt_pkg::ID_W-1:0]            o_entry_id,
    output logic signed [stt_pkg::EMA_W-1:0]    o_entry_ema,
    output logic [stt_pkg::CHAN_W-1:0]          o_entry_chan,
    output logic [stt_pkg::COUNT_W-1:0]         o_entry_count,
    output logic                                o_final_item
);

    localparam int IW = $clog2(TABLE_DEPTH);

    stt_pkg::t_ctl ctl;
    stt_pkg::t_sts sts;
    stt_pkg::t_rec rec;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rec_slot;
    logic [IW-1:0] rec_addr;
    logic [IW-1:0] res_addr;

    assign o_cfg_ready = 1'b1;

    stt_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_entry_count (o_entry_count),
        .o_final_item  (o_final_item),
        .i_sts         (sts),
        .o_ctl         (ctl),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_rec_slot    (rec_slot),
        .o_rec_addr    (rec_addr),
        .o_res_addr    (res_addr)
    );

    stt_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_drop_age_ms (i_cfg_drop_age_ms),
        .i_source_id       (i_source_id),
        .i_rssi_dbm        (i_rssi_dbm),
        .i_chan            (i_chan),
        .i_now_ms          (i_now_ms),
        .i_ctl             (ctl),
        .i_rd_addr         (rd_addr),
        .i_wr_addr         (wr_addr),
        .i_rec_slot        (rec_slot),
        .i_rec_addr        (rec_addr),
        .i_res_addr        (res_addr),
        .o_sts             (sts),
        .o_rec             (rec)
    );

    assign o_status     = rec.status;
    assign o_slot       = rec.slot;
    assign o_entry_id   = rec.id;
    assign o_entry_ema  = rec.ema;
    assign o_entry_chan = rec.chan;

endmodule

>>> src/stt_datapath.sv
module stt_datapath #(
    parameter int TABLE_DEPTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    input  logic [stt_pkg::SEEN_W-1:0]            i_cfg_drop_age_ms,
    input  logic [stt_pkg::ID_W-1:0]              i_source_id,
    input  logic signed [stt_pkg::RSSI_W-1:0]     i_rssi_dbm,
    input  logic [stt_pkg::CHAN_W-1:0]            i_chan,
    input  logic [stt_pkg::SEEN_W-1:0]            i_now_ms,
    input  stt_pkg::t_ctl                         i_ctl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        i_rd_addr,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        i_wr_addr,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        i_rec_slot,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        i_rec_addr,
    input  logic [$clog2(TABLE_DEPTH)-1:0]        i_res_addr,
    output stt_pkg::t_sts                         o_sts,
    output stt_pkg::t_rec                         o_rec
);

    stt_pkg::t_entry r_mem [TABLE_DEPTH];
    stt_pkg::t_rec   r_res_mem [TABLE_DEPTH];

    logic [stt_pkg::SEEN_W-1:0]        r_drop;
    logic [stt_pkg::ID_W-1:0]          r_id;
    logic signed [stt_pkg::RSSI_W-1:0] r_rssi;
    logic [stt_pkg::CHAN_W-1:0]        r_chan;
    logic [stt_pkg::SEEN_W-1:0]        r_now;
    stt_pkg::t_entry                   r_rd;
    stt_pkg::t_entry                   r_weak;
    stt_pkg::t_entry                   r_hold;
    stt_pkg::t_rec                     r_res;

    logic signed [stt_pkg::EMA_W-1:0]  target;
    logic signed [stt_pkg::EMA_W:0]    diff;
    logic signed [stt_pkg::EMA_W:0]    diff_adj;
    logic signed [stt_pkg::EMA_W:0]    step;
    logic signed [stt_pkg::EMA_W-1:0]  ema_upd;
    stt_pkg::t_entry                   wd;
    stt_pkg::t_rec                     rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop <= stt_pkg::DROP_AGE_RESET;
        end else if (i_cfg_valid) begin
            r_drop <= i_cfg_drop_age_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_id   <= i_source_id;
            r_rssi <= i_rssi_dbm;
            r_chan <= i_chan;
            r_now  <= i_now_ms;
        end
        if (i_ctl.load_weak) begin
            r_weak <= r_rd;
        end
        if (i_ctl.load_hold) begin
            r_hold <= r_rd;
        end
    end

    // ema step: (target - ema) / 4, truncated toward zero
    assign target   = {r_rssi, 4'b0000};
    assign diff     = {target[stt_pkg::EMA_W-1], target} - {r_rd.ema[stt_pkg::EMA_W-1], r_rd.ema};
    assign diff_adj = diff + (diff[stt_pkg::EMA_W] ? 13'sd3 : 13'sd0);
    assign step     = diff_adj >>> 2;
    assign ema_upd  = r_rd.ema + step[stt_pkg::EMA_W-1:0];

    always_comb begin
        case (i_ctl.wd_sel)
            stt_pkg::WD_UPD:  wd = '{id: r_id, ema: ema_upd, seen: r_now, chan: r_chan};
            stt_pkg::WD_TGT:  wd = '{id: r_id, ema: target, seen: r_now, chan: r_chan};
            stt_pkg::WD_RD:   wd = r_rd;
            stt_pkg::WD_HOLD: wd = r_hold;
            default:          wd = r_rd;
        endcase
    end

    always_comb begin
        rec.status = i_ctl.rec_status;
        rec.slot   = stt_pkg::SLOT_W'(i_rec_slot);
        case (i_ctl.rec_sel)
            stt_pkg::REC_WD: begin
                rec.id = wd.id; rec.ema = wd.ema; rec.chan = wd.chan;
            end
            stt_pkg::REC_RD: begin
                rec.id = r_rd.id; rec.ema = r_rd.ema; rec.chan = r_rd.chan;
            end
            stt_pkg::REC_WEAK: begin
                rec.id = r_weak.id; rec.ema = r_weak.ema; rec.chan = r_weak.chan;
            end
            default: begin
                rec.id = '0; rec.ema = '0; rec.chan = '0; rec.slot = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= wd;
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rec_wr) begin
            r_res_mem[i_rec_addr] <= rec;
        end
        if (i_ctl.res_rd_en) begin
            r_res <= r_res_mem[i_res_addr];
        end
    end

    assign o_sts.match        = (r_rd.id == r_id);
    assign o_sts.rd_less_weak = (r_rd.ema < r_weak.ema);
    assign o_sts.rd_less_hold = (r_rd.ema < r_hold.ema);
    assign o_sts.aged         = ((r_now - r_rd.seen) > r_drop);
    assign o_sts.tgt_le_weak  = (target <= r_weak.ema);
    assign o_rec              = r_res;

endmodule

>>> src/stt_ctrl.sv
module stt_ctrl #(
    parameter int TABLE_DEPTH = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [stt_pkg::CMD_W-1:0]          i_cmd,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [stt_pkg::COUNT_W-1:0]        o_entry_count,
    output logic                               o_final_item,
    input  stt_pkg::t_sts                      i_sts,
    output stt_pkg::t_ctl                      o_ctl,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_rd_addr,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_wr_addr,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_rec_slot,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_rec_addr,
    output logic [$clog2(TABLE_DEPTH)-1:0]     o_res_addr
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_SCAN    = 13'b0000000000010,
        S_AG_RD   = 13'b0000000000100,
        S_AG_CHK  = 13'b0000000001000,
        S_AG_MV   = 13'b0000000010000,
        S_SO_I    = 13'b0000000100000,
        S_SO_HOLD = 13'b0000001000000,
        S_SO_CMP  = 13'b0000010000000,
        S_SO_PUT  = 13'b0000100000000,
        S_LI_RD   = 13'b0001000000000,
        S_LI_WR   = 13'b0010000000000,
        S_DR_RD   = 13'b0100000000000,
        S_DR_WAIT = 13'b1000000000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_j, n_j;
    logic [IW-1:0]   r_pidx, n_pidx;
    logic            r_pv, n_pv;
    logic [IW-1:0]   r_weak_idx, n_weak_idx;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_k, n_k;
    logic            last_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_pidx  <= '0;
            r_pv    <= 1'b0;
            r_weak_idx <= '0;
            r_n     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_j     <= n_j;
            r_pidx  <= n_pidx;
            r_pv    <= n_pv;
            r_weak_idx <= n_weak_idx;
            r_n     <= n_n;
            r_k     <= n_k;
        end
    end

    assign last_res      = ((r_k + CW'(1)) == r_n);
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_DR_WAIT);
    assign o_final_item  = last_res;
    assign o_entry_count = stt_pkg::COUNT_W'(r_count);
    // the empty-sweep record is written from idle, before the count restarts
    assign o_rec_addr    = (r_state == S_IDLE) ? '0 : r_n[IW-1:0];
    assign o_res_addr    = r_k[IW-1:0];

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_pidx     = r_pidx;
        n_pv       = r_pv;
        n_weak_idx = r_weak_idx;
        n_count    = r_count;
        n_n        = r_n;
        n_k        = r_k;
        o_ctl      = '{wd_sel: stt_pkg::WD_RD, rec_sel: stt_pkg::REC_RD,
                       rec_status: stt_pkg::ST_UPDATED, default: 1'b0};
        o_rd_addr  = '0;
        o_wr_addr  = '0;
        o_rec_slot = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_i  = '0;
                    n_pv = 1'b0;
                    n_n  = '0;
                    n_k  = '0;
                    case (i_cmd)
                        stt_pkg::CMD_BEACON: n_state = S_SCAN;
                        stt_pkg::CMD_AGE:    n_state = S_AG_RD;
                        stt_pkg::CMD_SWEEP: begin
                            if (r_count == '0) begin
                                o_ctl.rec_wr     = 1'b1;
                                o_ctl.rec_sel    = stt_pkg::REC_ZERO;
                                o_ctl.rec_status = stt_pkg::ST_EMPTY;
                                n_n     = CW'(1);
                                n_state = S_DR_RD;
                            end else begin
                                n_i     = CW'(1);
                                n_state = S_SO_I;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end

            // read one entry per cycle, compare the one read last cycle
            S_SCAN: begin
                if (r_pv && i_sts.match) begin
                    o_ctl.wr_en      = 1'b1;
                    o_ctl.wd_sel     = stt_pkg::WD_UPD;
                    o_wr_addr        = r_pidx;
                    o_ctl.rec_wr     = 1'b1;
                    o_ctl.rec_sel    = stt_pkg::REC_WD;
                    o_ctl.rec_status = stt_pkg::ST_UPDATED;
                    o_rec_slot       = r_pidx;
                    n_n     = CW'(1);
                    n_state = S_DR_RD;
                end else begin
                    if (r_pv && (r_pidx == '0 || i_sts.rd_less_weak)) begin
                        o_ctl.load_weak = 1'b1;
                        n_weak_idx      = r_pidx;
                    end
                    if (r_i < r_count) begin
                        o_ctl.rd_en = 1'b1;
                        o_rd_addr   = r_i[IW-1:0];
                        n_pidx      = r_i[IW-1:0];
                        n_pv        = 1'b1;
                        n_i         = r_i + CW'(1);
                    end else begin
                        n_pv = 1'b0;
                        if (!r_pv) begin
                            o_ctl.rec_wr = 1'b1;
                            n_n          = CW'(1);
                            n_state      = S_DR_RD;
                            if (r_count < DEPTH_C) begin
                                o_ctl.wr_en      = 1'b1;
                                o_ctl.wd_sel     = stt_pkg::WD_TGT;
                                o_wr_addr        = r_count[IW-1:0];
                                o_ctl.rec_sel    = stt_pkg::REC_WD;
                                o_ctl.rec_status = stt_pkg::ST_INSERTED;
                                o_rec_slot       = r_count[IW-1:0];
                                n_count          = r_count + CW'(1);
                            end else if (i_sts.tgt_le_weak) begin
                                o_ctl.rec_sel    = stt_pkg::REC_WEAK;
                                o_ctl.rec_status = stt_pkg::ST_REJECTED;
                                o_rec_slot       = r_weak_idx;
                            end else begin
                                o_ctl.wr_en      = 1'b1;
                                o_ctl.wd_sel     = stt_pkg::WD_TGT;
                                o_wr_addr        = r_weak_idx;
                                o_ctl.rec_sel    = stt_pkg::REC_WD;
                                o_ctl.rec_status = stt_pkg::ST_REPLACED;
                                o_rec_slot       = r_weak_idx;
                            end
                        end
                    end
                end
            end

            S_AG_RD: begin
                if (r_i < r_count) begin
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = r_i[IW-1:0];
                    n_state     = S_AG_CHK;
                end else begin
                    n_k     = '0;
                    n_state = (r_n == '0) ? S_IDLE : S_DR_RD;
                end
            end

            S_AG_CHK: begin
                if (i_sts.aged) begin
                    o_ctl.rec_wr     = 1'b1;
                    o_ctl.rec_sel    = stt_pkg::REC_RD;
                    o_ctl.rec_status = stt_pkg::ST_AGED;
                    o_rec_slot       = r_i[IW-1:0];
                    n_n              = r_n + CW'(1);
                    n_count          = r_count - CW'(1);
                    // pull the last entry into the freed slot
                    if ((r_i + CW'(1)) < r_count) begin
                        o_ctl.rd_en = 1'b1;
                        o_rd_addr   = IW'(r_count - CW'(1));
                        n_state     = S_AG_MV;
                    end else begin
                        n_state = S_AG_RD;
                    end
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_AG_RD;
                end
            end

            S_AG_MV: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wd_sel = stt_pkg::WD_RD;
                o_wr_addr    = r_i[IW-1:0];
                n_state      = S_AG_CHK;
            end

            // insertion sort, strongest first
            S_SO_I: begin
                if (r_i < r_count) begin
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = r_i[IW-1:0];
                    n_state     = S_SO_HOLD;
                end else begin
                    n_i     = '0;
                    n_state = S_LI_RD;
                end
            end

            S_SO_HOLD: begin
                o_ctl.load_hold = 1'b1;
                n_j             = r_i[IW-1:0];
                o_ctl.rd_en     = 1'b1;
                o_rd_addr       = IW'(r_i - CW'(1));
                n_state         = S_SO_CMP;
            end

            S_SO_CMP: begin
                o_ctl.wr_en = 1'b1;
                o_wr_addr   = r_j;
                if (i_sts.rd_less_hold) begin
                    o_ctl.wd_sel = stt_pkg::WD_RD;
                    n_j          = r_j - IW'(1);
                    if (r_j - IW'(1) != '0) begin
                        o_ctl.rd_en = 1'b1;
                        o_rd_addr   = r_j - IW'(2);
                    end else begin
                        n_state = S_SO_PUT;
                    end
                end else begin
                    o_ctl.wd_sel = stt_pkg::WD_HOLD;
                    n_i          = r_i + CW'(1);
                    n_state      = S_SO_I;
                end
            end

            S_SO_PUT: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wd_sel = stt_pkg::WD_HOLD;
                o_wr_addr    = r_j;
                n_i          = r_i + CW'(1);
                n_state      = S_SO_I;
            end

            S_LI_RD: begin
                o_ctl.rd_en = 1'b1;
                o_rd_addr   = r_i[IW-1:0];
                n_state     = S_LI_WR;
            end

            S_LI_WR: begin
                o_ctl.rec_wr     = 1'b1;
                o_ctl.rec_sel    = stt_pkg::REC_RD;
                o_ctl.rec_status = stt_pkg::ST_LIST;
                o_rec_slot       = r_i[IW-1:0];
                n_n              = r_n + CW'(1);
                n_i              = r_i + CW'(1);
                if ((r_i + CW'(1)) < r_count) begin
                    n_state = S_LI_RD;
                end else begin
                    n_k     = '0;
                    n_state = S_DR_RD;
                end
            end

            S_DR_RD: begin
                o_ctl.res_rd_en = 1'b1;
                n_state         = S_DR_WAIT;
            end

            // hold the result until the receiver takes it
            S_DR_WAIT: begin
                if (i_out_ready) begin
                    if (last_res) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_DR_RD;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

endmodule
